// ===== rtl/core/lpsnr_pkg.sv =====
// Shared types, constants and controller codes for the luma PSNR meter.
`default_nettype none
package lpsnr_pkg;

	localparam int unsigned MAX_PIXELS_LOG2 = 24;
	localparam int unsigned LOG_FRAC_BITS   = 8;
	localparam int unsigned LG_FRAC         = 20;
	localparam int unsigned SSE_W           = 40;
	localparam int unsigned CNT_W           = 25;
	localparam int unsigned IDX_W           = 16;
	localparam int unsigned PSNR_W          = 15;
	localparam int unsigned POS_W           = 6;
	localparam int unsigned LG_W            = POS_W + LG_FRAC;
	localparam int unsigned MANT_W          = 31;
	localparam int unsigned IT_W            = 5;
	localparam int unsigned PROD_W          = 2 * LG_W;

	localparam logic [CNT_W-1:0]  PIXEL_COUNT_RST = CNT_W'(307200);
	localparam logic [CNT_W-1:0]  SIZE_MAX        = CNT_W'(1) << MAX_PIXELS_LOG2;
	localparam logic [15:0]       PEAK_SQ         = 16'd65025;
	localparam logic [CNT_W-1:0]  SAT_SCALE       = CNT_W'(1000000);
	localparam logic [LG_W-1:0]   TEN_LOG10_2_Q24 = LG_W'(50504453);
	localparam logic [PSNR_W-1:0] PSNR_SAT        = PSNR_W'(100 << LOG_FRAC_BITS);
	localparam int unsigned       RND_SHIFT       = 44 - LOG_FRAC_BITS;
	localparam logic [PROD_W:0]   RND_HALF        = (PROD_W+1)'(1) << (RND_SHIFT - 1);
	localparam logic [POS_W-1:0]  TOP_POS         = POS_W'(SSE_W - 1);
	localparam logic [IT_W-1:0]   IT_LAST         = IT_W'(LG_FRAC - 1);

	// register byte addresses, word index in paddr[2]
	localparam logic REG_PIXEL_COUNT = 1'b0;

	typedef struct packed {
		logic [7:0] ref_luma;
		logic [7:0] test_luma;
	} in_item_t;

	typedef struct packed {
		logic [PSNR_W-1:0] psnr_q8;
		logic [SSE_W-1:0]  frame_sse;
		logic [IDX_W-1:0]  frame_index;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MULA, ST_NORM_A, ST_ITER_A, ST_LOADB, ST_NORM_B,
		ST_ITER_B, ST_DIFF, ST_SCALE, ST_FIN, ST_DONE
	} lpsnr_state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_LOADA, OP_NORM, OP_SETM, OP_ITER,
		OP_LOADB, OP_DIFF, OP_SCALE, OP_FIN
	} lpsnr_op_t;

	typedef struct packed {
		lpsnr_op_t op;
		logic      busy;
		logic      done;
	} lpsnr_cmd_t;

	typedef struct packed {
		logic x_top;
		logic it_last;
		logic sat;
	} lpsnr_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/lpsnr_accum.sv =====
// Per-pixel squared-error accumulator, pixel and frame counters.
`default_nettype none
module lpsnr_accum (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          accept,
	input  wire lpsnr_pkg::in_item_t           item,
	input  wire logic [lpsnr_pkg::CNT_W-1:0]   pixel_count,
	output logic                               frame_end,
	output logic [lpsnr_pkg::SSE_W-1:0]        sse_out,
	output logic [lpsnr_pkg::CNT_W-1:0]        n_out,
	output logic [lpsnr_pkg::IDX_W-1:0]        idx_out
);
	import lpsnr_pkg::*;

	logic [SSE_W-1:0] sse_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] frame_q;
	logic signed [8:0] diff;
	logic [16:0]      sq;
	logic [SSE_W:0]   sum;
	logic [CNT_W-1:0] size;

	always_comb begin
		diff = $signed({1'b0, item.ref_luma}) - $signed({1'b0, item.test_luma});
		sq   = 17'(diff * diff);
		sum  = {1'b0, sse_q} + (SSE_W+1)'(sq);
		sse_out = sum[SSE_W] ? {SSE_W{1'b1}} : sum[SSE_W-1:0];
		if (pixel_count == '0) begin
			size = CNT_W'(1);
		end else if (pixel_count > SIZE_MAX) begin
			size = SIZE_MAX;
		end else begin
			size = pixel_count;
		end
		n_out     = cnt_q + CNT_W'(1);
		frame_end = (n_out >= size);
		idx_out   = frame_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sse_q   <= '0;
			cnt_q   <= '0;
			frame_q <= '0;
		end else if (accept) begin
			if (frame_end) begin
				sse_q   <= '0;
				cnt_q   <= '0;
				frame_q <= frame_q + IDX_W'(1);
			end else begin
				sse_q <= sse_out;
				cnt_q <= n_out;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/lpsnr_ctrl.sv =====
// Sequencer for the frame-end log2 / PSNR computation.
`default_nettype none
module lpsnr_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic                  take,
	input  wire lpsnr_pkg::lpsnr_stat_t stat,
	output lpsnr_pkg::lpsnr_cmd_t      cmd
);
	import lpsnr_pkg::*;

	lpsnr_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:   if (start) state_nxt = ST_MULA;
			ST_MULA:   state_nxt = ST_NORM_A;
			ST_NORM_A: begin
				if (stat.sat) state_nxt = ST_FIN;
				else if (stat.x_top) state_nxt = ST_ITER_A;
			end
			ST_ITER_A: if (stat.it_last) state_nxt = ST_LOADB;
			ST_LOADB:  state_nxt = ST_NORM_B;
			ST_NORM_B: if (stat.x_top) state_nxt = ST_ITER_B;
			ST_ITER_B: if (stat.it_last) state_nxt = ST_DIFF;
			ST_DIFF:   state_nxt = ST_SCALE;
			ST_SCALE:  state_nxt = ST_FIN;
			ST_FIN:    state_nxt = ST_DONE;
			ST_DONE:   if (take) state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op   = OP_NONE;
		cmd.busy = (state_q != ST_IDLE);
		cmd.done = (state_q == ST_DONE);
		unique case (state_q)
			ST_IDLE:   if (start) cmd.op = OP_LOAD;
			ST_MULA:   cmd.op = OP_LOADA;
			ST_NORM_A: begin
				if (stat.sat) cmd.op = OP_NONE;
				else if (stat.x_top) cmd.op = OP_SETM;
				else cmd.op = OP_NORM;
			end
			ST_ITER_A: cmd.op = OP_ITER;
			ST_LOADB:  cmd.op = OP_LOADB;
			ST_NORM_B: cmd.op = stat.x_top ? OP_SETM : OP_NORM;
			ST_ITER_B: cmd.op = OP_ITER;
			ST_DIFF:   cmd.op = OP_DIFF;
			ST_SCALE:  cmd.op = OP_SCALE;
			ST_FIN:    cmd.op = OP_FIN;
			ST_DONE:   cmd.op = OP_NONE;
			default:   cmd.op = OP_NONE;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/core/lpsnr_logdp.sv =====
// Datapath for the frame-end PSNR: normalize, square-and-halve log2, scale.
`default_nettype none
module lpsnr_logdp (
	input  wire logic                        clk,
	input  wire lpsnr_pkg::lpsnr_cmd_t       cmd,
	input  wire logic [lpsnr_pkg::SSE_W-1:0] sse_in,
	input  wire logic [lpsnr_pkg::CNT_W-1:0] n_in,
	input  wire logic [lpsnr_pkg::IDX_W-1:0] idx_in,
	output lpsnr_pkg::lpsnr_stat_t           stat,
	output lpsnr_pkg::out_item_t             result
);
	import lpsnr_pkg::*;

	logic [SSE_W-1:0]   sse_q;
	logic [CNT_W-1:0]   n_q;
	logic [IDX_W-1:0]   idx_q;
	logic               sat_q;
	logic [SSE_W-1:0]   x_q;
	logic [POS_W-1:0]   p_q;
	logic [MANT_W-1:0]  m_q;
	logic [LG_FRAC-1:0] frac_q;
	logic [IT_W-1:0]    it_q;
	logic [LG_W-1:0]    la_q;
	logic [LG_W-1:0]    d_q;
	logic [PROD_W-1:0]  prod_q;
	logic [PSNR_W-1:0]  psnr_q;

	logic [2*MANT_W-1:0] msq;
	logic [MANT_W:0]     mt;
	logic [CNT_W-1:0]    small_sse;
	logic [LG_W-1:0]     lb;
	logic [PROD_W:0]     rnd;
	logic [PROD_W-RND_SHIFT:0] q;

	always_comb begin
		msq       = (2*MANT_W)'(m_q) * (2*MANT_W)'(m_q);
		mt        = msq[2*MANT_W-1:MANT_W-1];
		small_sse = CNT_W'(sse_q[4:0]) * SAT_SCALE;
		lb        = {p_q, frac_q};
		rnd       = {1'b0, prod_q} + RND_HALF;
		q         = rnd[PROD_W:RND_SHIFT];
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				sse_q <= sse_in;
				n_q   <= n_in;
				idx_q <= idx_in;
			end
			OP_LOADA: begin
				x_q   <= SSE_W'(n_q) * SSE_W'(PEAK_SQ);
				p_q   <= TOP_POS;
				// mean squared error below 1e-6: sse*1e6 < n, only possible for sse < 17
				sat_q <= (sse_q[SSE_W-1:5] == '0) && (small_sse < n_q);
			end
			OP_NORM: begin
				x_q <= {x_q[SSE_W-2:0], 1'b0};
				p_q <= p_q - POS_W'(1);
			end
			OP_SETM: begin
				m_q    <= x_q[SSE_W-1:SSE_W-MANT_W];
				frac_q <= '0;
				it_q   <= '0;
			end
			OP_ITER: begin
				frac_q <= {frac_q[LG_FRAC-2:0], mt[MANT_W]};
				m_q    <= mt[MANT_W] ? mt[MANT_W:1] : mt[MANT_W-1:0];
				it_q   <= it_q + IT_W'(1);
			end
			OP_LOADB: begin
				la_q <= {p_q, frac_q};
				x_q  <= sse_q;
				p_q  <= TOP_POS;
			end
			OP_DIFF:  d_q <= (la_q > lb) ? la_q - lb : '0;
			OP_SCALE: prod_q <= PROD_W'(d_q) * PROD_W'(TEN_LOG10_2_Q24);
			OP_FIN: begin
				if (sat_q || q > (PROD_W-RND_SHIFT+1)'(PSNR_SAT)) begin
					psnr_q <= PSNR_SAT;
				end else begin
					psnr_q <= q[PSNR_W-1:0];
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		stat.x_top   = x_q[SSE_W-1];
		stat.it_last = (it_q == IT_LAST);
		stat.sat     = sat_q;
		result.psnr_q8     = psnr_q;
		result.frame_sse   = sse_q;
		result.frame_index = idx_q;
	end

endmodule
`default_nettype wire

// ===== rtl/core/luma_psnr_per_frame_core.sv =====
// Top level of the per-frame luma PSNR meter.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------
//  in      | input     | in_valid / in_stall  | in_item  (ref_luma, test_luma)
//  out     | output    | out_valid / out_stall| out_item (psnr_q8, frame_sse, frame_index)
//  cfg     | input     | APB psel/penable     | pixel_count at byte address 0
//
// Pixels are taken one per cycle while no frame is in the log engine. The
// item that closes a frame starts the log engine, and in_stall stays high
// until its result moves to the output register: a setup state that forms
// 65025*N, normalize (up to 24 shifts for 65025*N, up to 39 for SSE, one bit
// per cycle, then a mantissa load each), 20 squaring steps per operand on the
// shared 31x31 multiplier, then subtract, scale, round and hand-off. A
// near-zero-error frame skips the logs and takes the saturated value.
// The output register frees the engine while a result waits on out_stall.
// Reset clears counters, sum, controller and output valid; pixel_count
// returns to 307200.
`default_nettype none
module luma_psnr_per_frame_core (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire lpsnr_pkg::in_item_t  in_item,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output lpsnr_pkg::out_item_t      out_item,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [2:0]           paddr,
	input  wire logic [31:0]          pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);
	import lpsnr_pkg::*;

	logic [CNT_W-1:0] pixel_count_q;
	logic             in_acc;
	logic             frame_end;
	logic [SSE_W-1:0] acc_sse;
	logic [CNT_W-1:0] acc_n;
	logic [IDX_W-1:0] acc_idx;
	logic             take;
	logic             out_valid_q;
	out_item_t        out_item_q;
	lpsnr_cmd_t       cmd;
	lpsnr_stat_t      stat;
	out_item_t        dp_result;

	// config port: writes decode on word index only
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_count_q <= PIXEL_COUNT_RST;
		end else if (psel && penable && pwrite && paddr[2] == REG_PIXEL_COUNT) begin
			pixel_count_q <= pwdata[CNT_W-1:0];
		end
	end
	assign prdata = (paddr[2] == REG_PIXEL_COUNT) ? 32'(pixel_count_q) : '0;

	// input side: stall while the log engine holds a frame
	assign in_stall = cmd.busy;
	assign in_acc   = in_valid && !cmd.busy;

	lpsnr_accum u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (in_acc),
		.item        (in_item),
		.pixel_count (pixel_count_q),
		.frame_end   (frame_end),
		.sse_out     (acc_sse),
		.n_out       (acc_n),
		.idx_out     (acc_idx)
	);

	lpsnr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_acc && frame_end),
		.take   (take),
		.stat   (stat),
		.cmd    (cmd)
	);

	lpsnr_logdp u_logdp (
		.clk    (clk),
		.cmd    (cmd),
		.sse_in (acc_sse),
		.n_in   (acc_n),
		.idx_in (acc_idx),
		.stat   (stat),
		.result (dp_result)
	);

	// output register
	assign take = cmd.done && (!out_valid_q || !out_stall);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (take) begin
			out_item_q <= dp_result;
		end
	end
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// no pixel is taken while a frame result is in flight
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_valid && !in_stall && cmd.busy))
		else $error("pixel accepted while log engine busy");

	// result never overwrites a pending one
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> (!out_valid_q || !out_stall))
		else $error("output register overwritten");

	// PSNR stays within the saturation cap
	a_psnr_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_item_q.psnr_q8 <= PSNR_SAT))
		else $error("psnr above cap");

	// zero error gives the saturated value
	a_zero_sse: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_item_q.frame_sse == '0) |-> (out_item_q.psnr_q8 == PSNR_SAT))
		else $error("zero sse not saturated");

endmodule
`default_nettype wire
